[sv/queue_delay_averager_assert.svh]
// assertion macros for the queueing delay averager
`ifndef QUEUE_DELAY_AVERAGER_ASSERT_SVH
`define QUEUE_DELAY_AVERAGER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define QDA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define QDA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define QDA_ASSERT_IMP(label, ante, cons, msg)
`define QDA_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[sv/qda_pkg.sv]
// shared types and constants for the queueing delay averager
`timescale 1ns / 1ps

package qda_pkg;

  // fixed field widths
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned SUM_W    = 56;
  localparam int unsigned CNT_W    = 24;
  localparam int unsigned AVG_W    = 32;
  localparam int unsigned PERIOD_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  // event codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ENQ  = 2'd0;
  localparam cmd_t CMD_DEQ  = 2'd1;
  localparam cmd_t CMD_TICK = 2'd2;

  // divider control from the sequencer
  typedef struct packed {
    logic start;
    logic ack;
  } div_ctrl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/qda_ram.sv]
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module qda_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/qda_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module qda_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qda_pkg::div_ctrl_t          ctrl_i,
  input  logic [qda_pkg::SUM_W-1:0]   dividend_i,
  input  logic [qda_pkg::CNT_W-1:0]   divisor_i,
  output qda_pkg::div_stat_t          stat_o,
  output logic [qda_pkg::SUM_W-1:0]   quotient_o
);

  import qda_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } dstate_e;

  dstate_e             state_q;
  logic [STEP_W-1:0]   step_q;
  logic [SUM_W-1:0]    dvd_q;
  logic [CNT_W-1:0]    dvs_q;
  logic [CNT_W-1:0]    rem_q;

  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      diff;
  logic                qbit;
  logic [CNT_W-1:0]    rem_d;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, dvd_q[SUM_W-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
      dvd_q   <= '0;
      dvs_q   <= '0;
      rem_q   <= '0;
    end else begin
      case (state_q)
        D_IDLE: begin
          if (ctrl_i.start) begin
            dvd_q   <= dividend_i;
            dvs_q   <= divisor_i;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q  <= rem_d;
          dvd_q  <= {dvd_q[SUM_W-2:0], qbit};
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(SUM_W - 1)) begin
            state_q <= D_DONE;
          end
        end
        D_DONE: begin
          if (ctrl_i.ack) begin
            state_q <= D_IDLE;
          end
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy = (state_q == D_RUN);
  assign stat_o.done = (state_q == D_DONE);
  assign quotient_o  = dvd_q;

endmodule

[sv/queue_delay_averager.sv]
// queueing delay averager top level: timestamp fifo, sums and period average
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o  | cmd_i, timestamp_i
//  out     | output    | out_valid_o / out_stall_i| avg_delay_o, sample_delay_o, flags
//  cfg     | input     | cfg_we_i                 | cfg_wdata_i (period_ticks)
//
// enqueue, dequeue and ticks that need no division pass through accept, then
// an execute step that reads the fifo ram result and loads the output register.
// a tick that ends a period with a nonzero sum and count runs the divider,
// one quotient bit a cycle over 56 bits, before the average is loaded.
// a stalled output register holds the execute step, so nothing is lost.
// reset clears pointers, sums and counters; the fifo ram needs no clearing.
`timescale 1ns / 1ps

module queue_delay_averager #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [qda_pkg::PERIOD_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [qda_pkg::TIME_W-1:0]    timestamp_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [qda_pkg::AVG_W-1:0]     avg_delay_o,
  output logic [qda_pkg::TIME_W-1:0]    sample_delay_o,
  output logic                          sample_valid_o,
  output logic                          empty_skip_o,
  output logic                          full_drop_o,
  output logic                          avg_updated_o
);

  import qda_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned LVL_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_e;

  state_e               state_q;
  cmd_t                 cmd_q;
  logic [TIME_W-1:0]    ts_q;
  logic [PERIOD_W-1:0]  period_q;
  logic [PTR_W-1:0]     head_q;
  logic [PTR_W-1:0]     tail_q;
  logic [LVL_W-1:0]     level_q;
  logic [SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]     count_q;
  logic [AVG_W-1:0]     average_q;
  logic [PERIOD_W-1:0]  tick_q;

  logic                 out_valid_q;
  logic [AVG_W-1:0]     avg_delay_q;
  logic [TIME_W-1:0]    sample_delay_q;
  logic                 sample_valid_q;
  logic                 empty_skip_q;
  logic                 full_drop_q;
  logic                 avg_updated_q;

  logic                 accept;
  logic                 out_free;
  logic                 fifo_full;
  logic                 fifo_empty;
  logic [TIME_W-1:0]    ram_rdata;
  logic                 ram_we;
  logic                 ram_re;
  logic [TIME_W-1:0]    smp_delay;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_sat;
  logic [PERIOD_W:0]    tick_next;
  logic                 period_end;
  logic                 need_div;
  logic                 load_out;

  logic [AVG_W-1:0]     res_avg;
  logic [TIME_W-1:0]    res_sample;
  logic                 res_valid;
  logic                 res_skip;
  logic                 res_drop;
  logic                 res_upd;

  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic [SUM_W-1:0]     div_quot;
  logic [AVG_W-1:0]     quot_sat;

  // handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // fifo status
  assign fifo_full  = (level_q == LVL_W'(FIFO_DEPTH));
  assign fifo_empty = (level_q == '0);

  // ram ports: read the head at accept, write the tail in execute
  assign ram_re = accept && (cmd_i == CMD_DEQ);
  assign ram_we = (state_q == S_EXEC) && out_free && (cmd_q == CMD_ENQ) && !fifo_full;

  qda_ram #(
    .WIDTH (TIME_W),
    .DEPTH (FIFO_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ts_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // delay sample, saturating sum and tick period check
  always_comb begin
    smp_delay  = ts_q - ram_rdata;
    sum_add    = {1'b0, sum_q} + {(SUM_W + 1 - TIME_W)'(0), smp_delay};
    sum_sat    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    tick_next  = {1'b0, tick_q} + 1'b1;
    period_end = (tick_next >= {1'b0, period_q});
    need_div   = (cmd_q == CMD_TICK) && period_end && (sum_q != '0) && (count_q != '0);
  end

  // divider hookup
  assign div_ctrl.start = (state_q == S_EXEC) && out_free && need_div;
  assign div_ctrl.ack   = (state_q == S_DIV) && div_stat.done && out_free;
  assign quot_sat = (div_quot[SUM_W-1:AVG_W] != '0) ? '1 : div_quot[AVG_W-1:0];

  qda_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  // result fields for the output register
  always_comb begin
    res_avg    = average_q;
    res_sample = '0;
    res_valid  = 1'b0;
    res_skip   = 1'b0;
    res_drop   = 1'b0;
    res_upd    = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      S_EXEC: begin
        load_out = out_free && !need_div;
        case (cmd_q)
          CMD_ENQ: begin
            res_drop = fifo_full;
          end
          CMD_DEQ: begin
            res_skip   = fifo_empty;
            res_valid  = !fifo_empty;
            res_sample = fifo_empty ? '0 : smp_delay;
          end
          CMD_TICK: begin
            if (period_end) begin
              res_avg = '0;
              res_upd = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        load_out = div_stat.done && out_free;
        res_avg  = quot_sat;
        res_upd  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cmd_q          <= CMD_ENQ;
      ts_q           <= '0;
      period_q       <= PERIOD_RESET;
      head_q         <= '0;
      tail_q         <= '0;
      level_q        <= '0;
      sum_q          <= '0;
      count_q        <= '0;
      average_q      <= '0;
      tick_q         <= '0;
      out_valid_q    <= 1'b0;
      avg_delay_q    <= '0;
      sample_delay_q <= '0;
      sample_valid_q <= 1'b0;
      empty_skip_q   <= 1'b0;
      full_drop_q    <= 1'b0;
      avg_updated_q  <= 1'b0;
    end else begin
      // configuration write
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end

      // load a finished result, or free the register on an output transfer
      if (load_out) begin
        out_valid_q    <= 1'b1;
        avg_delay_q    <= res_avg;
        sample_delay_q <= res_sample;
        sample_valid_q <= res_valid;
        empty_skip_q   <= res_skip;
        full_drop_q    <= res_drop;
        avg_updated_q  <= res_upd;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_i;
            ts_q    <= timestamp_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_q <= need_div ? S_DIV : S_IDLE;
            case (cmd_q)
              CMD_ENQ: begin
                if (!fifo_full) begin
                  tail_q  <= (tail_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                  level_q <= level_q + 1'b1;
                end
              end
              CMD_DEQ: begin
                if (!fifo_empty) begin
                  head_q  <= (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
                  level_q <= level_q - 1'b1;
                  sum_q   <= sum_sat;
                  if (count_q != '1) begin
                    count_q <= count_q + 1'b1;
                  end
                end
              end
              CMD_TICK: begin
                if (period_end) begin
                  sum_q   <= '0;
                  count_q <= '0;
                  tick_q  <= '0;
                  if (!need_div) begin
                    average_q <= '0;
                  end
                end else begin
                  tick_q <= tick_next[PERIOD_W-1:0];
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_stat.done && out_free) begin
            average_q <= quot_sat;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // output ports
  assign out_valid_o    = out_valid_q;
  assign avg_delay_o    = avg_delay_q;
  assign sample_delay_o = sample_delay_q;
  assign sample_valid_o = sample_valid_q;
  assign empty_skip_o   = empty_skip_q;
  assign full_drop_o    = full_drop_q;
  assign avg_updated_o  = avg_updated_q;

  // checks
  `include "queue_delay_averager_assert.svh"

  `QDA_ASSERT_NXT(a_accept_exec, accept, state_q == S_EXEC, "accepted item did not execute")
  `QDA_ASSERT_IMP(a_level_range, 1'b1, level_q <= LVL_W'(FIFO_DEPTH), "fifo level overflow")
  `QDA_ASSERT_IMP(a_empty_ptrs, level_q == '0, head_q == tail_q, "empty fifo with split pointers")
  `QDA_ASSERT_IMP(a_div_owner, div_stat != '0, state_q == S_DIV, "stray divider activity")

endmodule

[tb/tb.sv]
// self-checking testbench for the queueing delay averager
`timescale 1ns / 1ps

module tb;
  import qda_pkg::*;

  localparam int unsigned STAMP_DEPTH     = 256;
  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned EXP_SLOTS       = 16;
  localparam int unsigned ROW_SLOTS       = 64;
  localparam cmd_t CMD_RSVD = 2'd3;
  localparam logic [SUM_W-1:0]  SUM_SAT  = '1;
  localparam logic [CNT_W-1:0]  CNT_SAT  = '1;
  localparam logic [AVG_W-1:0]  AVG_SAT  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // one result transfer, flags in the order valid, skip, drop, update
  typedef struct packed {
    logic [AVG_W-1:0]  avg;
    logic [TIME_W-1:0] sample;
    logic              valid;
    logic              skip;
    logic              drop;
    logic              upd;
  } delay_result_t;

  // one row of the directed stimulus
  typedef struct packed {
    logic                is_cfg;
    logic [PERIOD_W-1:0] period;
    cmd_t                cmd;
    logic [TIME_W-1:0]   stamp;
    logic                typed;
    delay_result_t       want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [PERIOD_W-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  cmd_t                cmd_i;
  logic [TIME_W-1:0]   timestamp_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [AVG_W-1:0]    avg_delay_o;
  logic [TIME_W-1:0]   sample_delay_o;
  logic                sample_valid_o;
  logic                empty_skip_o;
  logic                full_drop_o;
  logic                avg_updated_o;

  // predictor state
  logic [TIME_W-1:0]   sim_stamps [STAMP_DEPTH];
  int unsigned         sim_head;
  int unsigned         sim_tail;
  int unsigned         sim_level;
  logic [SUM_W-1:0]    sim_sum;
  logic [CNT_W-1:0]    sim_count;
  logic [AVG_W-1:0]    sim_avg;
  logic [PERIOD_W-1:0] sim_ticks;
  logic [PERIOD_W-1:0] sim_period;

  // expected results in transfer order, and the directed rows
  delay_result_t expected_fifo [EXP_SLOTS];
  int unsigned   exp_wr = 0;
  int unsigned   exp_rd = 0;
  stim_row_t     stim_rows [ROW_SLOTS];
  int unsigned   n_rows = 0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_grants   = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned cycles        = 0;
  int unsigned n_items       = 0;
  int unsigned n_results     = 0;
  int unsigned n_mismatch    = 0;
  int unsigned n_samples     = 0;
  int unsigned n_skips       = 0;
  int unsigned n_drops       = 0;
  int unsigned n_updates     = 0;

  queue_delay_averager #(
    .FIFO_DEPTH(STAMP_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .timestamp_i   (timestamp_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .avg_delay_o   (avg_delay_o),
    .sample_delay_o(sample_delay_o),
    .sample_valid_o(sample_valid_o),
    .empty_skip_o  (empty_skip_o),
    .full_drop_o   (full_drop_o),
    .avg_updated_o (avg_updated_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("queue_delay_averager: mismatch");
      $finish;
    end
  end

  // expected result of one event, advancing the predictor state
  function automatic delay_result_t predict_delay_result(cmd_t cmd,
                                                         logic [TIME_W-1:0] stamp);
    delay_result_t r;
    logic [63:0]   room;
    logic [63:0]   quot;
    logic [16:0]   next_ticks;
    r = '0;
    case (cmd)
      CMD_ENQ: begin
        if (sim_level >= STAMP_DEPTH) begin
          r.drop = 1'b1;
        end else begin
          sim_stamps[sim_tail] = stamp;
          sim_tail = (sim_tail + 1) % STAMP_DEPTH;
          sim_level++;
        end
      end
      CMD_DEQ: begin
        if (sim_level == 0) begin
          r.skip = 1'b1;
        end else begin
          r.sample = stamp - sim_stamps[sim_head];
          r.valid = 1'b1;
          sim_head = (sim_head + 1) % STAMP_DEPTH;
          sim_level--;
          room = SUM_SAT - sim_sum;
          if (r.sample > room) sim_sum = SUM_SAT;
          else sim_sum = sim_sum + r.sample;
          if (sim_count != CNT_SAT) sim_count++;
        end
      end
      CMD_TICK: begin
        next_ticks = sim_ticks + 17'd1;
        if (next_ticks >= sim_period) begin
          quot = '0;
          if (sim_sum != '0 && sim_count != '0) quot = sim_sum / sim_count;
          sim_avg = (quot > AVG_SAT) ? AVG_SAT : quot[AVG_W-1:0];
          sim_sum = '0;
          sim_count = '0;
          sim_ticks = '0;
          r.upd = 1'b1;
        end else begin
          sim_ticks = next_ticks[PERIOD_W-1:0];
        end
      end
      default: ;
    endcase
    r.avg = sim_avg;
    return r;
  endfunction

  // directed rows
  function automatic void append_row(stim_row_t row);
    stim_rows[n_rows] = row;
    n_rows++;
  endfunction

  function automatic void add_event(cmd_t cmd, logic [TIME_W-1:0] stamp);
    stim_row_t row;
    row = '0;
    row.cmd = cmd;
    row.stamp = stamp;
    append_row(row);
  endfunction

  function automatic void add_checked(cmd_t cmd, logic [TIME_W-1:0] stamp,
                                      logic [AVG_W-1:0] avg, logic [TIME_W-1:0] sample,
                                      logic [3:0] flags);
    stim_row_t row;
    row = '0;
    row.cmd = cmd;
    row.stamp = stamp;
    row.typed = 1'b1;
    row.want = {avg, sample, flags};
    append_row(row);
  endfunction

  function automatic void add_period(logic [PERIOD_W-1:0] period);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.period = period;
    append_row(row);
  endfunction

  function automatic logic [TIME_W-1:0] rand_stamp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_W-1:0];
  endfunction

  // dequeue time relative to the oldest stored stamp
  function automatic logic [TIME_W-1:0] dequeue_stamp();
    logic [TIME_W-1:0] base;
    if (sim_level == 0) return rand_stamp();
    base = sim_stamps[sim_head];
    case ($urandom_range(0, 3))
      0: return base + $urandom_range(0, 1000);
      1: return base + rand_stamp();
      2: return base - 1'b1;
      default: return base + $urandom_range(0, 100000);
    endcase
  endfunction

  // offer one event, predict on its transfer
  task automatic send_event(cmd_t cmd, logic [TIME_W-1:0] stamp, logic typed,
                            delay_result_t want);
    delay_result_t got;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    cmd_i       = cmd;
    timestamp_i = stamp;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    got = predict_delay_result(cmd, stamp);
    expected_fifo[exp_wr % EXP_SLOTS] = typed ? want : got;
    exp_wr++;
    n_items++;
  endtask

  task automatic send_random(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) send_event(CMD_ENQ, rand_stamp(), 1'b0, '0);
      else if (pick < 76) send_event(CMD_DEQ, dequeue_stamp(), 1'b0, '0);
      else if (pick < 95) send_event(CMD_TICK, rand_stamp(), 1'b0, '0);
      else send_event(CMD_RSVD, rand_stamp(), 1'b0, '0);
    end
  endtask

  // period write once every result is out
  task automatic write_period(logic [PERIOD_W-1:0] period);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (exp_wr != exp_rd) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = period;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    sim_period = period;
  endtask

  // receiver stall, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_grants != hold_seen) begin
      hold_seen = hold_grants;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checking
  always @(posedge clk_i) begin : check_results
    delay_result_t seen;
    delay_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {avg_delay_o, sample_delay_o, sample_valid_o, empty_skip_o, full_drop_o,
              avg_updated_o};
      n_results++;
      if (exp_wr == exp_rd) begin
        n_mismatch++;
        if (n_mismatch <= REPORT_LIMIT)
          $display("result %0d with nothing expected: avg %h sample %h flags %b",
                   n_results, seen.avg, seen.sample, seen[3:0]);
      end else begin
        want = expected_fifo[exp_rd % EXP_SLOTS];
        exp_rd++;
        n_samples += want.valid;
        n_skips   += want.skip;
        n_drops   += want.drop;
        n_updates += want.upd;
        if (seen !== want) begin
          n_mismatch++;
          if (n_mismatch <= REPORT_LIMIT)
            $display("result %0d: expected avg %h sample %h flags %b, %s %h %h %b",
                     n_results, want.avg, want.sample, want[3:0], "got",
                     seen.avg, seen.sample, seen[3:0]);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [TIME_W-1:0] stamp;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_ENQ;
    timestamp_i = '0;
    sim_head    = 0;
    sim_tail    = 0;
    sim_level   = 0;
    sim_sum     = '0;
    sim_count   = '0;
    sim_avg     = '0;
    sim_ticks   = '0;
    sim_period  = PERIOD_RESET;

    // directed rows, flags are valid, skip, drop, update
    add_checked(CMD_DEQ,  '0, '0, '0, 4'b0100);
    add_checked(CMD_ENQ,  TIME_MAX, '0, '0, 4'b0000);
    add_checked(CMD_DEQ,  '0, '0, 48'd1, 4'b1000);
    add_checked(CMD_RSVD, TIME_MAX, '0, '0, 4'b0000);
    add_checked(CMD_TICK, TIME_MAX, '0, '0, 4'b0000);
    add_checked(CMD_ENQ,  '0, '0, '0, 4'b0000);
    add_checked(CMD_DEQ,  TIME_MAX, '0, TIME_MAX, 4'b1000);
    add_checked(CMD_ENQ,  48'h8000_0000_0000, '0, '0, 4'b0000);
    add_checked(CMD_DEQ,  48'h8000_0000_0000, '0, '0, 4'b1000);
    add_event(CMD_ENQ, 48'h5555_5555_5555);
    add_event(CMD_ENQ, 48'hAAAA_AAAA_AAAA);
    add_event(CMD_DEQ, 48'hAAAA_AAAA_AAAA);
    add_event(CMD_DEQ, 48'h5555_5555_5555);
    add_period(16'd2);
    // huge delays over few samples saturate the average
    add_checked(CMD_TICK, '0, AVG_SAT, '0, 4'b0001);
    add_checked(CMD_TICK, '0, AVG_SAT, '0, 4'b0000);
    add_checked(CMD_TICK, '0, '0, '0, 4'b0001);
    add_period(16'd0);
    add_checked(CMD_TICK, TIME_MAX, '0, '0, 4'b0001);
    add_checked(CMD_ENQ,  48'd100, '0, '0, 4'b0000);
    add_checked(CMD_DEQ,  48'd130, '0, 48'd30, 4'b1000);
    add_checked(CMD_ENQ,  '0, '0, '0, 4'b0000);
    add_checked(CMD_DEQ,  48'd6, '0, 48'd6, 4'b1000);
    add_checked(CMD_TICK, '0, 32'd18, '0, 4'b0001);
    add_checked(CMD_DEQ,  48'h1234, 32'd18, '0, 4'b0100);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned i = 0; i < n_rows; i++) begin
      if (stim_rows[i].is_cfg) write_period(stim_rows[i].period);
      else send_event(stim_rows[i].cmd, stim_rows[i].stamp, stim_rows[i].typed,
                      stim_rows[i].want);
    end

    // longest period, ticks pile up
    write_period(16'hFFFF);
    send_random(60);

    // period lowered below the ticks already counted
    write_period(16'd3);
    send_idle_pct = 45;
    send_random(60);

    // every tick closes a period
    write_period(16'd1);
    send_idle_pct = 0;
    stall_pct     = 45;
    send_random(60);

    // sum saturation: empty the fifo and close the period first
    send_idle_pct = 28;
    stall_pct     = 28;
    while (sim_level != 0) send_event(CMD_DEQ, dequeue_stamp(), 1'b0, '0);
    send_event(CMD_TICK, rand_stamp(), 1'b0, '0);
    write_period(16'hFFFF);

    // fill past full under a long output hold-off
    hold_grants++;
    repeat (STAMP_DEPTH + 3) send_event(CMD_ENQ, rand_stamp(), 1'b0, '0);

    // drain with the largest delay, then a small one tips the sum over
    repeat (STAMP_DEPTH) send_event(CMD_DEQ, sim_stamps[sim_head] - 1'b1, 1'b0, '0);
    stamp = rand_stamp();
    send_event(CMD_ENQ, stamp, 1'b0, '0);
    send_event(CMD_DEQ, stamp + $urandom_range(300, 1 << 20), 1'b0, '0);
    write_period(16'd1);
    send_event(CMD_TICK, rand_stamp(), 1'b0, '0);

    // short period, both sides idling
    write_period(16'd5);
    send_random(60);

    // drain
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    n_mismatch += exp_wr - exp_rd;

    $display("%0d events sent, %0d results: %0d samples, %0d empty skips,",
             n_items, n_results, n_samples, n_skips);
    $display("%0d full drops, %0d period ends, periods 0 to 65535, saturated sum",
             n_drops, n_updates);
    $display("and average, %0d-cycle output hold-off", HOLD_OFF_CYCLES);
    if (n_mismatch == 0) begin
      $display("queue_delay_averager: match");
    end else begin
      $display("queue_delay_averager: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/qda_pkg.sv
sv/qda_ram.sv
sv/qda_div.sv
sv/queue_delay_averager.sv
tb/tb.sv
